// ----- hdl/cpps_pkg.sv -----
// Package for the converter precharge and protection sequencer.
// Holds request and result structs, sequence states and register indexes.
// No dependencies.
package cpps_pkg;

  // Measurement width (signed Q11.4) and default tick counter width
  localparam int MEAS_BITS      = 16;
  localparam int COUNT_BITS_DEF = 24;
  localparam int CFG_INDEX_BITS = 3;

  // Register indexes on the configuration port
  localparam logic [CFG_INDEX_BITS-1:0] CFG_CURRENT_LIMIT     = 3'd0;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_BUS_VOLTAGE_MAX   = 3'd1;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_BUS_VOLTAGE_MIN   = 3'd2;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_TEMPERATURE_MAX   = 3'd3;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_PRECHARGE_VOLTAGE = 3'd4;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_STAGE_DELAY       = 3'd5;

  // Register reset values
  localparam logic [MEAS_BITS-2:0]        CURRENT_LIMIT_RST     = 15'd240;
  localparam logic signed [MEAS_BITS-1:0] BUS_VOLTAGE_MAX_RST   = 16'sd2880;
  localparam logic signed [MEAS_BITS-1:0] BUS_VOLTAGE_MIN_RST   = -16'sd160;
  localparam logic signed [MEAS_BITS-1:0] TEMPERATURE_MAX_RST   = 16'sd960;
  localparam logic signed [MEAS_BITS-1:0] PRECHARGE_VOLTAGE_RST = 16'sd1920;
  localparam int                          STAGE_DELAY_RST       = 10000;

  // Fault flag bit positions
  localparam int FLT_PHASE_A  = 0;
  localparam int FLT_PHASE_B  = 1;
  localparam int FLT_PHASE_C  = 2;
  localparam int FLT_BUS_HIGH = 3;
  localparam int FLT_BUS_LOW  = 4;
  localparam int FLT_OVERTEMP = 5;
  localparam int FLT_COUNT    = 6;

  typedef enum logic [2:0] {
    ST_INIT      = 3'd0,
    ST_PRECHARGE = 3'd1,
    ST_BYPASS    = 3'd2,
    ST_IDLE      = 3'd3,
    ST_RUNNING   = 3'd4
  } seq_state_t;

  typedef struct packed {
    logic                  enable_request;
    logic                  disable_request;
    logic signed [MEAS_BITS-1:0] current_a;
    logic signed [MEAS_BITS-1:0] current_b;
    logic signed [MEAS_BITS-1:0] current_c;
    logic signed [MEAS_BITS-1:0] dc_voltage;
    logic signed [MEAS_BITS-1:0] temperature;
  } req_t;

  typedef struct packed {
    logic [2:0] mode;
    logic       gate_enable;
    logic       precharge_relay;
    logic       bypass_relay;
    logic       fault_phase_a;
    logic       fault_phase_b;
    logic       fault_phase_c;
    logic       fault_bus_high;
    logic       fault_bus_low;
    logic       fault_overtemp;
  } result_t;

endpackage

// ----- hdl/converter_precharge_protection_sequencer_unit.sv -----
// Converter precharge and protection sequencer, top level.
// Depends on cpps_pkg for the request/result structs, states and register indexes.
//
// Usage:
//  - Input channel (in_valid, in_stall, in_data): one request per control tick
//    with enable/disable commands and five signed Q11.4 measurements.
//  - Output channel (out_valid, out_stall, out_data): one result per request,
//    carrying mode, gate enable, relay drives and the six sticky fault flags,
//    all taken from the sequencer state after that tick.
//  - Configuration port (cfg_we, cfg_index, cfg_data): writes trip levels,
//    precharge voltage and stage delay; write only while no request is in flight.
//  - A request accepted into the input register has its result loaded into
//    the result register when it moves on, with no register between the two.
//    Throughput is one request per cycle while out_stall is low, set by the
//    combinational state update between the two registers.
//  - When out_stall is high with a result pending, the result holds and the
//    input register still takes one more request; in_stall rises once both
//    are full and drops as soon as the result is taken.
//  - Synchronous reset puts the sequence in init, clears the tick counter and
//    fault flags, restores register defaults and empties both stages.
module converter_precharge_protection_sequencer_unit #(
  parameter int COUNT_BITS = cpps_pkg::COUNT_BITS_DEF,
  parameter int CFG_BITS   = (COUNT_BITS > cpps_pkg::MEAS_BITS) ? COUNT_BITS
                                                                : cpps_pkg::MEAS_BITS
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  cpps_pkg::req_t                      in_data,
  output logic                                out_valid,
  input  logic                                out_stall,
  output cpps_pkg::result_t                   out_data,
  input  logic                                cfg_we,
  input  logic [cpps_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [CFG_BITS-1:0]                 cfg_data
);
  import cpps_pkg::*;

  localparam int CMP_BITS = MEAS_BITS + 1;

  // Configuration registers
  logic [MEAS_BITS-2:0]        current_limit;
  logic signed [MEAS_BITS-1:0] bus_voltage_max;
  logic signed [MEAS_BITS-1:0] bus_voltage_min;
  logic signed [MEAS_BITS-1:0] temperature_max;
  logic signed [MEAS_BITS-1:0] precharge_voltage;
  logic [COUNT_BITS-1:0]       stage_delay;

  // Sequencer state
  seq_state_t            state;
  seq_state_t            state_next;
  logic [COUNT_BITS-1:0] tick_count;
  logic [COUNT_BITS-1:0] tick_count_next;
  logic [COUNT_BITS-1:0] tick_inc;
  logic [FLT_COUNT-1:0]  fault_flags;
  logic [FLT_COUNT-1:0]  fault_flags_next;

  // Pipeline registers
  logic    stage_valid;
  req_t    stage_data;
  logic    out_ready;
  logic    adv;
  result_t result_next;

  // Trip detection
  logic signed [CMP_BITS-1:0] lim_pos;
  logic signed [CMP_BITS-1:0] lim_neg;
  logic [FLT_COUNT-1:0]       trips;
  logic                       delay_done;

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      current_limit     <= CURRENT_LIMIT_RST;
      bus_voltage_max   <= BUS_VOLTAGE_MAX_RST;
      bus_voltage_min   <= BUS_VOLTAGE_MIN_RST;
      temperature_max   <= TEMPERATURE_MAX_RST;
      precharge_voltage <= PRECHARGE_VOLTAGE_RST;
      stage_delay       <= COUNT_BITS'(STAGE_DELAY_RST);
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_CURRENT_LIMIT:     current_limit     <= cfg_data[MEAS_BITS-2:0];
        CFG_BUS_VOLTAGE_MAX:   bus_voltage_max   <= $signed(cfg_data[MEAS_BITS-1:0]);
        CFG_BUS_VOLTAGE_MIN:   bus_voltage_min   <= $signed(cfg_data[MEAS_BITS-1:0]);
        CFG_TEMPERATURE_MAX:   temperature_max   <= $signed(cfg_data[MEAS_BITS-1:0]);
        CFG_PRECHARGE_VOLTAGE: precharge_voltage <= $signed(cfg_data[MEAS_BITS-1:0]);
        CFG_STAGE_DELAY:       stage_delay       <= cfg_data[COUNT_BITS-1:0];
        default: ;
      endcase
    end
  end

  // Handshake: the result register frees when empty or being taken
  assign out_ready = !out_valid || !out_stall;
  assign adv       = stage_valid && out_ready;
  assign in_stall  = stage_valid && !out_ready;

  // Hold the request in the input register until it moves on
  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (in_valid && !in_stall) begin
      stage_valid <= 1'b1;
    end else if (adv) begin
      stage_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      stage_data <= in_data;
    end
  end

  // Compare each measurement against its trip level
  always_comb begin
    lim_pos = $signed({2'b00, current_limit});
    lim_neg = -lim_pos;
    trips = '0;
    trips[FLT_PHASE_A] = (CMP_BITS'(stage_data.current_a) > lim_pos) ||
                         (CMP_BITS'(stage_data.current_a) < lim_neg);
    trips[FLT_PHASE_B] = (CMP_BITS'(stage_data.current_b) > lim_pos) ||
                         (CMP_BITS'(stage_data.current_b) < lim_neg);
    trips[FLT_PHASE_C] = (CMP_BITS'(stage_data.current_c) > lim_pos) ||
                         (CMP_BITS'(stage_data.current_c) < lim_neg);
    trips[FLT_BUS_HIGH] = stage_data.dc_voltage > bus_voltage_max;
    trips[FLT_BUS_LOW]  = stage_data.dc_voltage < bus_voltage_min;
    trips[FLT_OVERTEMP] = stage_data.temperature > temperature_max;
  end

  // Saturating tick count, compared after the increment
  assign tick_inc   = (tick_count == '1) ? tick_count : tick_count + 1'b1;
  assign delay_done = tick_inc > stage_delay;

  // Sequence transitions for the request in the input register
  always_comb begin
    state_next       = state;
    tick_count_next  = tick_inc;
    fault_flags_next = fault_flags;
    case (state)
      ST_PRECHARGE: begin
        if (delay_done && (stage_data.dc_voltage > precharge_voltage)) begin
          state_next      = ST_BYPASS;
          tick_count_next = '0;
        end
        if (stage_data.disable_request) begin
          state_next      = ST_INIT;
          tick_count_next = '0;
        end
      end
      ST_BYPASS: begin
        if (delay_done) begin
          state_next      = ST_IDLE;
          tick_count_next = '0;
        end
        if (stage_data.disable_request) begin
          state_next      = ST_INIT;
          tick_count_next = '0;
        end
      end
      ST_IDLE: begin
        if (stage_data.enable_request && (trips == '0)) begin
          fault_flags_next = '0;
          state_next       = ST_RUNNING;
        end
        if (stage_data.disable_request) begin
          state_next      = ST_INIT;
          tick_count_next = '0;
        end
      end
      ST_RUNNING: begin
        // counter keeps running on the way out of running
        if (stage_data.disable_request) begin
          state_next = ST_INIT;
        end
        if (trips != '0) begin
          fault_flags_next = fault_flags | trips;
          state_next       = ST_INIT;
        end
      end
      default: begin
        if (stage_data.enable_request && delay_done) begin
          state_next      = ST_PRECHARGE;
          tick_count_next = '0;
        end
      end
    endcase
  end

  // Build the result from the updated state
  always_comb begin
    result_next.mode            = state_next;
    result_next.gate_enable     = (state_next == ST_RUNNING);
    result_next.precharge_relay = (state_next != ST_INIT);
    result_next.bypass_relay    = state_next inside {ST_BYPASS, ST_IDLE, ST_RUNNING};
    result_next.fault_phase_a   = fault_flags_next[FLT_PHASE_A];
    result_next.fault_phase_b   = fault_flags_next[FLT_PHASE_B];
    result_next.fault_phase_c   = fault_flags_next[FLT_PHASE_C];
    result_next.fault_bus_high  = fault_flags_next[FLT_BUS_HIGH];
    result_next.fault_bus_low   = fault_flags_next[FLT_BUS_LOW];
    result_next.fault_overtemp  = fault_flags_next[FLT_OVERTEMP];
  end

  // Advance the sequencer state once per request
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_INIT;
      tick_count  <= '0;
      fault_flags <= '0;
    end else if (adv) begin
      state       <= state_next;
      tick_count  <= tick_count_next;
      fault_flags <= fault_flags_next;
    end
  end

  // Load or drop the result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_data <= result_next;
    end
  end

  // Checks
  a_state_only_on_adv: assert property (@(posedge clk) disable iff (rst)
    !adv |=> ($stable(tick_count) && $stable(fault_flags) && $stable(state)))
    else $error("sequencer state changed without a request");

  a_trip_exits_running: assert property (@(posedge clk) disable iff (rst)
    (adv && (state == ST_RUNNING) && (trips != '0)) |=> (state == ST_INIT))
    else $error("trip in running did not return to init");

  a_running_entry_clean: assert property (@(posedge clk) disable iff (rst)
    ((state == ST_RUNNING) && ($past(state) != ST_RUNNING)) |-> (fault_flags == '0))
    else $error("entered running with fault flags set");

  a_stall_needs_full: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (stage_valid && out_valid))
    else $error("input stalled with a free stage");

endmodule
